### sv/kepf_pkg.sv
// ----------------------------------------------------------------------------
// kepf_pkg
// Shared types, codes and sizes of the kuwahara edge-preserving filter unit.
// ----------------------------------------------------------------------------
`default_nettype none

package kepf_pkg;

    // stream item kinds
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_RADIUS = 8;

    localparam logic [12:0] CFG_WIDTH_RST  = 13'd640;
    localparam logic [15:0] CFG_HEIGHT_RST = 16'd480;
    localparam logic [3:0]  CFG_RADIUS_RST = 4'd3;

    // sizes for a quadrant of at most 9x9 pixels
    localparam int SUMW  = 15;
    localparam int SQW   = 23;
    localparam int NW    = 7;
    localparam int PRODW = 30;
    localparam int VARW  = 32;
    localparam int OFSW  = 5;

    typedef struct packed {
        logic                   clear;
        logic                   pix_wr;
        logic                   sweep_vld;
        logic signed [OFSW-1:0] dx;
        logic signed [OFSW-1:0] dy;
        logic                   prod_vld;
        logic [1:0]             prod_q;
        logic [1:0]             prod_c;
        logic                   acc_vld;
        logic [1:0]             acc_q;
        logic [1:0]             acc_c;
        logic                   div_init;
        logic                   div_step;
        logic [2:0]             div_bit;
        logic                   finish;
    } t_cmd;

    typedef struct packed {
        logic input_done;
        logic emit_due;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic left;
        logic right;
        logic top;
        logic bot;
        logic ctr;
    } t_tap;

endpackage

`default_nettype wire

### sv/kepf_ctrl.sv
// ----------------------------------------------------------------------------
// kepf_ctrl
// Sequencer: window sweep, variance pass, mean division and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module kepf_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_vld,
    input  wire              i_in_op,
    input  wire [3:0]        i_eff_r,
    input  kepf_pkg::t_sts   i_sts,
    output logic             o_in_rdy,
    output kepf_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_SWEEP, S_DRAIN, S_VAR, S_VWAIT, S_DINIT, S_DIV, S_FINISH
    } t_state;

    t_state                          r_state;
    logic signed [kepf_pkg::OFSW-1:0] r_dx;
    logic signed [kepf_pkg::OFSW-1:0] r_dy;
    logic                            r_cnt;
    logic [1:0]                      r_vq;
    logic [1:0]                      r_vc;
    logic                            r_acc_vld;
    logic [1:0]                      r_acc_q;
    logic [1:0]                      r_acc_c;
    logic [2:0]                      r_dbit;

    logic signed [kepf_pkg::OFSW-1:0] w_lim;
    logic                            w_start;

    assign w_lim    = $signed({1'b0, i_eff_r});
    assign o_in_rdy = (r_state == S_IDLE);
    assign w_start  = i_in_vld && (r_state == S_IDLE) &&
                      (((i_in_op == kepf_pkg::OP_PIXEL) && i_sts.emit_due) ||
                       ((i_in_op == kepf_pkg::OP_FLUSH) && i_sts.input_done));

    always_comb begin
        o_cmd           = '0;
        o_cmd.pix_wr    = i_in_vld && (r_state == S_IDLE) &&
                          (i_in_op == kepf_pkg::OP_PIXEL) && !i_sts.input_done;
        o_cmd.clear     = w_start;
        o_cmd.sweep_vld = (r_state == S_SWEEP);
        o_cmd.dx        = r_dx;
        o_cmd.dy        = r_dy;
        o_cmd.prod_vld  = (r_state == S_VAR);
        o_cmd.prod_q    = r_vq;
        o_cmd.prod_c    = r_vc;
        o_cmd.acc_vld   = r_acc_vld;
        o_cmd.acc_q     = r_acc_q;
        o_cmd.acc_c     = r_acc_c;
        o_cmd.div_init  = (r_state == S_DINIT);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.div_bit   = r_dbit;
        o_cmd.finish    = (r_state == S_FINISH) && i_sts.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dx      <= '0;
            r_dy      <= '0;
            r_cnt     <= 1'b0;
            r_vq      <= '0;
            r_vc      <= '0;
            r_acc_vld <= 1'b0;
            r_acc_q   <= '0;
            r_acc_c   <= '0;
            r_dbit    <= '0;
        end else begin
            r_acc_vld <= (r_state == S_VAR);
            unique case (r_state)
                S_IDLE: begin
                    if (w_start) begin
                        r_dx    <= -w_lim;
                        r_dy    <= -w_lim;
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (r_dx == w_lim) begin
                        r_dx <= -w_lim;
                        if (r_dy == w_lim) begin
                            r_cnt   <= 1'b0;
                            r_state <= S_DRAIN;
                        end else begin
                            r_dy <= r_dy + kepf_pkg::OFSW'(1);
                        end
                    end else begin
                        r_dx <= r_dx + kepf_pkg::OFSW'(1);
                    end
                end
                S_DRAIN: begin
                    if (r_cnt) begin
                        r_vq    <= '0;
                        r_vc    <= '0;
                        r_state <= S_VAR;
                    end else begin
                        r_cnt <= 1'b1;
                    end
                end
                S_VAR: begin
                    r_acc_q   <= r_vq;
                    r_acc_c   <= r_vc;
                    if (r_vc == 2'd2) begin
                        r_vc <= '0;
                        r_vq <= r_vq + 2'd1;
                        if (r_vq == 2'd3) begin
                            r_state <= S_VWAIT;
                        end
                    end else begin
                        r_vc <= r_vc + 2'd1;
                    end
                end
                S_VWAIT: begin
                    r_state <= S_DINIT;
                end
                S_DINIT: begin
                    r_dbit  <= 3'd7;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_dbit == 3'd0) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_dbit <= r_dbit - 3'd1;
                    end
                end
                S_FINISH: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/kepf_dpath.sv
// ----------------------------------------------------------------------------
// kepf_dpath
// Line store, raster counters, quadrant accumulators, variance and mean units.
// ----------------------------------------------------------------------------
`default_nettype none

module kepf_dpath #(
    parameter int MAX_WIDTH  = kepf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = kepf_pkg::DEF_MAX_RADIUS,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int LW = XW + 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  kepf_pkg::t_cmd   i_cmd,
    input  wire [31:0]       i_in_data,
    input  wire [WW-1:0]     i_eff_w,
    input  wire [15:0]       i_eff_h,
    input  wire [kepf_pkg::NW-1:0] i_n,
    input  wire [LW-1:0]     i_lag,
    input  wire              i_out_rdy,
    output kepf_pkg::t_sts   o_sts,
    output logic             o_out_vld,
    output logic [31:0]      o_out_data,
    output logic             o_out_last
);

    localparam int NROWS = 2 * MAX_RADIUS + 2;
    localparam int SW    = $clog2(NROWS);
    localparam int SLW   = SW + 2;
    localparam int XSW   = XW + 2;
    localparam int DEPTH = NROWS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [AW-1:0] f_addr(input logic [SW-1:0] slot,
                                             input logic [XW-1:0] col);
        f_addr = AW'(slot) * AW'(MAX_WIDTH) + AW'(col);
    endfunction

    logic [31:0] mem [DEPTH];

    // raster counters
    logic [XW-1:0] r_icol;
    logic [15:0]   r_irow;
    logic [SW-1:0] r_islot;
    logic [LW-1:0] r_ilin;
    logic [XW-1:0] r_ocol;
    logic [15:0]   r_orow;
    logic [SW-1:0] r_oslot;
    logic [LW-1:0] r_olin;

    // window sweep pipeline
    logic                  r_a_vld;
    kepf_pkg::t_tap        r_a_tap;
    logic [SW-1:0]         r_a_slot;
    logic [XW-1:0]         r_a_xc;
    logic                  r_b_vld;
    kepf_pkg::t_tap        r_b_tap;
    logic [31:0]           r_b_data;

    logic [kepf_pkg::SUMW-1:0] r_s  [4][3];
    logic [kepf_pkg::SQW-1:0]  r_s2 [4][3];
    logic [7:0]                r_alpha;

    logic [kepf_pkg::PRODW-1:0] r_p1;
    logic [kepf_pkg::PRODW-1:0] r_p2;
    logic [kepf_pkg::VARW-1:0]  r_vacc;
    logic [kepf_pkg::VARW-1:0]  r_best;
    logic [1:0]                 r_bsel;

    logic [kepf_pkg::SUMW-1:0] r_rem [3];
    logic [7:0]                r_quo [3];

    logic        r_o_vld;
    logic [31:0] r_o_data;
    logic        r_o_last;

    logic                    w_done;
    logic signed [XSW-1:0]   a_xs;
    logic [XW-1:0]           a_xc;
    logic signed [17:0]      a_ys;
    logic signed [5:0]       a_d;
    logic signed [SLW-1:0]   a_sl;
    logic [SW-1:0]           a_slot;
    kepf_pkg::t_tap          a_tap;
    logic [kepf_pkg::VARW-1:0] v_next;
    logic [XW:0]             n_icol;
    logic [XW:0]             n_ocol;
    logic [16:0]             n_orow;

    assign w_done         = (r_irow >= i_eff_h);
    assign o_sts.input_done = w_done;
    assign o_sts.emit_due = !w_done &&
                            ({1'b0, r_ilin} >= ({1'b0, r_olin} + {1'b0, i_lag}));
    assign o_sts.out_free = !r_o_vld || i_out_rdy;
    assign o_out_vld      = r_o_vld;
    assign o_out_data     = r_o_data;
    assign o_out_last     = r_o_last;

    assign n_icol = {1'b0, r_icol} + (XW+1)'(1);
    assign n_ocol = {1'b0, r_ocol} + (XW+1)'(1);
    assign n_orow = {1'b0, r_orow} + 17'd1;

    // clamped tap position and its row slot
    always_comb begin
        a_xs = $signed({2'b00, r_ocol}) + XSW'(i_cmd.dx);
        if (a_xs < 0) begin
            a_xc = '0;
        end else if (a_xs >= $signed(XSW'(i_eff_w))) begin
            a_xc = XW'(i_eff_w - WW'(1));
        end else begin
            a_xc = a_xs[XW-1:0];
        end
        a_ys = $signed({2'b00, r_orow}) + 18'(i_cmd.dy);
        if (a_ys < 0) begin
            a_d = 6'(18'sd0 - $signed({2'b00, r_orow}));
        end else if (a_ys >= $signed({2'b00, i_eff_h})) begin
            a_d = 6'($signed({2'b00, i_eff_h}) - 18'sd1 - $signed({2'b00, r_orow}));
        end else begin
            a_d = 6'(i_cmd.dy);
        end
        a_sl = $signed({2'b00, r_oslot}) + SLW'(a_d);
        if (a_sl < 0) begin
            a_slot = SW'(a_sl + $signed(SLW'(NROWS)));
        end else if (a_sl >= $signed(SLW'(NROWS))) begin
            a_slot = SW'(a_sl - $signed(SLW'(NROWS)));
        end else begin
            a_slot = a_sl[SW-1:0];
        end
        a_tap.left  = (i_cmd.dx <= 0);
        a_tap.right = (i_cmd.dx >= 0);
        a_tap.top   = (i_cmd.dy <= 0);
        a_tap.bot   = (i_cmd.dy >= 0);
        a_tap.ctr   = (i_cmd.dx == 0) && (i_cmd.dy == 0);
    end

    always_comb begin
        v_next = ((i_cmd.acc_c == 2'd0) ? '0 : r_vacc) +
                 kepf_pkg::VARW'(r_p1) - kepf_pkg::VARW'(r_p2);
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_wr) begin
            mem[f_addr(r_islot, r_icol)] <= i_in_data;
        end
        r_b_data <= mem[f_addr(r_a_slot, r_a_xc)];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_icol  <= '0;
            r_irow  <= '0;
            r_islot <= '0;
            r_ilin  <= '0;
            r_ocol  <= '0;
            r_orow  <= '0;
            r_oslot <= '0;
            r_olin  <= '0;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_a_vld <= i_cmd.sweep_vld;
            r_b_vld <= r_a_vld;
            if (i_cmd.finish) begin
                r_o_vld <= 1'b1;
            end else if (r_o_vld && i_out_rdy) begin
                r_o_vld <= 1'b0;
            end
            if (i_cmd.pix_wr) begin
                r_ilin <= r_ilin + LW'(1);
                if (n_icol >= (XW+1)'(i_eff_w)) begin
                    r_icol <= '0;
                    r_irow <= r_irow + 16'd1;
                    r_islot <= (r_islot == SW'(NROWS - 1)) ? '0 : r_islot + SW'(1);
                end else begin
                    r_icol <= n_icol[XW-1:0];
                end
            end
            if (i_cmd.finish) begin
                if ((n_ocol >= (XW+1)'(i_eff_w)) && (n_orow >= {1'b0, i_eff_h})) begin
                    r_icol  <= '0;
                    r_irow  <= '0;
                    r_islot <= '0;
                    r_ilin  <= '0;
                    r_ocol  <= '0;
                    r_orow  <= '0;
                    r_oslot <= '0;
                    r_olin  <= '0;
                end else if (n_ocol >= (XW+1)'(i_eff_w)) begin
                    r_olin  <= r_olin + LW'(1);
                    r_ocol  <= '0;
                    r_orow  <= n_orow[15:0];
                    r_oslot <= (r_oslot == SW'(NROWS - 1)) ? '0 : r_oslot + SW'(1);
                end else begin
                    r_olin <= r_olin + LW'(1);
                    r_ocol <= n_ocol[XW-1:0];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_a_tap  <= a_tap;
        r_a_slot <= a_slot;
        r_a_xc   <= a_xc;
        r_b_tap  <= r_a_tap;
        if (i_cmd.clear) begin
            for (int q = 0; q < 4; q++) begin
                for (int c = 0; c < 3; c++) begin
                    r_s[q][c]  <= '0;
                    r_s2[q][c] <= '0;
                end
            end
        end else if (r_b_vld) begin
            for (int q = 0; q < 4; q++) begin
                if ((q[0] ? r_b_tap.right : r_b_tap.left) &&
                    (q[1] ? r_b_tap.bot : r_b_tap.top)) begin
                    for (int c = 0; c < 3; c++) begin
                        r_s[q][c]  <= r_s[q][c] + kepf_pkg::SUMW'(r_b_data[8*c +: 8]);
                        r_s2[q][c] <= r_s2[q][c] + kepf_pkg::SQW'(
                                      r_b_data[8*c +: 8] * r_b_data[8*c +: 8]);
                    end
                end
            end
            if (r_b_tap.ctr) begin
                r_alpha <= r_b_data[31:24];
            end
        end
        if (i_cmd.prod_vld) begin
            r_p1 <= kepf_pkg::PRODW'(i_n * r_s2[i_cmd.prod_q][i_cmd.prod_c]);
            r_p2 <= kepf_pkg::PRODW'(r_s[i_cmd.prod_q][i_cmd.prod_c] *
                                     r_s[i_cmd.prod_q][i_cmd.prod_c]);
        end
        if (i_cmd.acc_vld) begin
            r_vacc <= v_next;
            if ((i_cmd.acc_c == 2'd2) && ((i_cmd.acc_q == 2'd0) || (v_next < r_best))) begin
                r_best <= v_next;
                r_bsel <= i_cmd.acc_q;
            end
        end
        if (i_cmd.div_init) begin
            for (int c = 0; c < 3; c++) begin
                r_rem[c] <= r_s[r_bsel][c];
                r_quo[c] <= '0;
            end
        end else if (i_cmd.div_step) begin
            for (int c = 0; c < 3; c++) begin
                if (r_rem[c] >= (kepf_pkg::SUMW'(i_n) << i_cmd.div_bit)) begin
                    r_rem[c] <= r_rem[c] - (kepf_pkg::SUMW'(i_n) << i_cmd.div_bit);
                    r_quo[c][i_cmd.div_bit] <= 1'b1;
                end
            end
        end
        if (i_cmd.finish) begin
            r_o_data <= {r_alpha, r_quo[2], r_quo[1], r_quo[0]};
            r_o_last <= (n_ocol >= (XW+1)'(i_eff_w)) && (n_orow >= {1'b0, i_eff_h});
        end
    end

endmodule

`default_nettype wire

### sv/kuwahara_edge_preserving_filter_unit.sv
// ----------------------------------------------------------------------------
// kuwahara_edge_preserving_filter_unit
// Four-quadrant kuwahara filter on a raster stream of ARGB pixels.
// ----------------------------------------------------------------------------
// Pixels are taken in raster order and kept in a line store of
// (2*MAX_RADIUS+2)*MAX_WIDTH words; the store needs no clearing pass after
// reset. An item that gives a result is worked in steps: the window is
// read one pixel per cycle through the single read port of the line
// store, then the four variances are computed, then the three means; no
// new item is taken meanwhile. The output register lets the next item in
// while a result waits. Flush items drain the last R rows and R pixels of
// a frame, R the clamped radius; the result with tlast ends the frame.
`default_nettype none

module kuwahara_edge_preserving_filter_unit #(
    parameter int MAX_WIDTH  = kepf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = kepf_pkg::DEF_MAX_RADIUS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [31:0]  s_axis_tdata,   // in_red, in_green, in_blue, in_alpha
    input  wire         s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic        m_axis_tlast,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [3:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int LW = XW + 16;
    localparam int CW = 14;

    logic [12:0] r_width;
    logic [15:0] r_height;
    logic [3:0]  r_radius;
    logic [LW-1:0]           r_lag;
    logic [kepf_pkg::NW-1:0] r_n;

    logic [WW-1:0]   w_eff_w;
    logic [15:0]     w_eff_h;
    logic [3:0]      w_eff_r;
    logic            w_wr;
    kepf_pkg::t_cmd  w_cmd;
    kepf_pkg::t_sts  w_sts;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        if (r_width == 13'd0) begin
            w_eff_w = WW'(1);
        end else if (CW'(r_width) > CW'(MAX_WIDTH)) begin
            w_eff_w = WW'(MAX_WIDTH);
        end else begin
            w_eff_w = WW'(r_width);
        end
        w_eff_h = (r_height == 16'd0) ? 16'd1 : r_height;
        if (r_radius == 4'd0) begin
            w_eff_r = 4'd1;
        end else if (r_radius > 4'(MAX_RADIUS)) begin
            w_eff_r = 4'(MAX_RADIUS);
        end else begin
            w_eff_r = r_radius;
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            kepf_pkg::REG_WIDTH:  prdata = {19'd0, r_width};
            kepf_pkg::REG_HEIGHT: prdata = {16'd0, r_height};
            kepf_pkg::REG_RADIUS: prdata = {28'd0, r_radius};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= kepf_pkg::CFG_WIDTH_RST;
            r_height <= kepf_pkg::CFG_HEIGHT_RST;
            r_radius <= kepf_pkg::CFG_RADIUS_RST;
        end else if (w_wr) begin
            priority if (paddr[3:2] == kepf_pkg::REG_WIDTH) begin
                r_width <= pwdata[12:0];
            end else if (paddr[3:2] == kepf_pkg::REG_HEIGHT) begin
                r_height <= pwdata[15:0];
            end else if (paddr[3:2] == kepf_pkg::REG_RADIUS) begin
                r_radius <= pwdata[3:0];
            end
        end
    end

    // derived window constants
    always_ff @(posedge i_clk) begin
        r_lag <= LW'(w_eff_r * w_eff_w + w_eff_r);
        r_n   <= kepf_pkg::NW'((w_eff_r + 4'd1) * (w_eff_r + 4'd1));
    end

    kepf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_vld (s_axis_tvalid),
        .i_in_op  (s_axis_tuser),
        .i_eff_r  (w_eff_r),
        .i_sts    (w_sts),
        .o_in_rdy (s_axis_tready),
        .o_cmd    (w_cmd)
    );

    kepf_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_data  (s_axis_tdata),
        .i_eff_w    (w_eff_w),
        .i_eff_h    (w_eff_h),
        .i_n        (r_n),
        .i_lag      (r_lag),
        .i_out_rdy  (m_axis_tready),
        .o_sts      (w_sts),
        .o_out_vld  (m_axis_tvalid),
        .o_out_data (m_axis_tdata),
        .o_out_last (m_axis_tlast)
    );

`ifndef ASSERT_OFF
    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result written over a waiting result");

    a_sweep_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.sweep_vld |-> !s_axis_tready)
        else $error("input taken during window sweep");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.finish))
        else $error("result shown without a finished item");

    a_store_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pix_wr |-> !w_cmd.sweep_vld && !w_cmd.finish)
        else $error("line store written while an item is at work");
`endif

endmodule

`default_nettype wire
